// ----- rtl/fmtps_pkg.sv -----
// ----------------------------------------------------------------------------
// fmtps_pkg - shared types and constants of the FM tuner port sequencer
// Request codes, port byte codes, wait codes and the structs that pass
// between the sequencer, the divider and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package fmtps_pkg;

	// field widths
	localparam int unsigned REQ_W   = 2;
	localparam int unsigned FREQ_W  = 21;
	localparam int unsigned VOL_W   = 4;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned WAIT_W  = 2;

	// request codes
	localparam logic [REQ_W-1:0] REQ_FREQ  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_VOL   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_MUTE  = 2'd2;
	localparam logic [REQ_W-1:0] REQ_QUERY = 2'd3;

	// wait codes
	localparam logic [WAIT_W-1:0] WAIT_NONE  = 2'd0;
	localparam logic [WAIT_W-1:0] WAIT_1MS   = 2'd1;
	localparam logic [WAIT_W-1:0] WAIT_100MS = 2'd2;
	localparam logic [WAIT_W-1:0] WAIT_2S    = 2'd3;

	// port byte codes
	localparam logic [BYTE_W-1:0] PORT_BIT_BASE  = 8'hD1;
	localparam logic [BYTE_W-1:0] PORT_ON        = 8'hD8;
	localparam logic [BYTE_W-1:0] PORT_OFF       = 8'hD0;
	localparam logic [BYTE_W-1:0] PORT_RAMP_DOWN = 8'h48;
	localparam logic [BYTE_W-1:0] PORT_VOL_UP    = 8'h98;
	localparam logic [BYTE_W-1:0] PORT_VOL_DOWN  = 8'h58;
	localparam logic [BYTE_W-1:0] PORT_NONE      = 8'h00;

	// frequency arithmetic: (f + IF) / 800, 22-bit dividend
	localparam int unsigned DVD_W     = FREQ_W + 1;
	localparam int unsigned FREQ_DIV  = 800;
	localparam logic [DVD_W-1:0] IF_OFFSET = 22'd171200;

	// 800 = 2^5 * 25: shift out the power of two, then multiply by
	// ceil(2^22 / 25) and keep bits 22 and up; exact for 17-bit operands
	localparam int unsigned DIV_PRE = 5;
	localparam int unsigned RCP_W   = 18;
	localparam int unsigned RCP_SH  = 22;
	localparam logic [RCP_W-1:0] DIV_RCP = 18'd167773;

	// serial tuning word
	localparam int unsigned WORD_LEN = 24;
	localparam int unsigned BIT_CNT_W = $clog2(WORD_LEN);
	localparam logic [WORD_LEN-1:0] WORD_TAIL = 24'hA00000;

	localparam int unsigned FREQ_BITS_DEF = 13;

	// divider start request and response
	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quo;
	} div_rsp_t;

	// one result from the sequencer to the output register
	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] port_byte;
		logic [WAIT_W-1:0] wait_code;
		logic              write_valid;
		logic              signal_present;
		logic              last;
	} emit_t;

endpackage

`default_nettype wire

// ----- rtl/fmtps_req_if.sv -----
// ----------------------------------------------------------------------------
// fmtps_req_if - request channel
// valid/ready channel carrying one tuner request.
// ----------------------------------------------------------------------------
`default_nettype none

interface fmtps_req_if;
	import fmtps_pkg::*;

	logic                valid;
	logic                ready;
	logic [REQ_W-1:0]    req_type;
	logic [FREQ_W-1:0]   tune_freq;
	logic [VOL_W-1:0]    volume_level;
	logic [BYTE_W-1:0]   port_read;

	modport source (
		output valid, req_type, tune_freq, volume_level, port_read,
		input  ready
	);

	modport sink (
		input  valid, req_type, tune_freq, volume_level, port_read,
		output ready
	);

endinterface

`default_nettype wire

// ----- rtl/fmtps_res_if.sv -----
// ----------------------------------------------------------------------------
// fmtps_res_if - result channel
// valid/ready channel carrying one port byte with its delay code.
// ----------------------------------------------------------------------------
`default_nettype none

interface fmtps_res_if;
	import fmtps_pkg::*;

	logic                valid;
	logic                ready;
	logic [BYTE_W-1:0]   port_byte;
	logic [WAIT_W-1:0]   wait_code;
	logic                write_valid;
	logic                signal_present;
	logic                last;

	modport source (
		output valid, port_byte, wait_code, write_valid, signal_present, last,
		input  ready
	);

	modport sink (
		input  valid, port_byte, wait_code, write_valid, signal_present, last,
		output ready
	);

endinterface

`default_nettype wire

// ----- rtl/fmtps_div.sv -----
// ----------------------------------------------------------------------------
// fmtps_div - divide by the PLL reference step
// Reciprocal multiply: the dividend is latched on start, the quotient is
// registered from the product, and done pulses as that quotient appears.
// ----------------------------------------------------------------------------
`default_nettype none

module fmtps_div (
	input  logic                clk,
	input  logic                arst_n,
	input  fmtps_pkg::div_req_t dreq,
	output fmtps_pkg::div_rsp_t drsp
);
	import fmtps_pkg::*;

	localparam int unsigned SCL_W = DVD_W - DIV_PRE;
	localparam int unsigned PRD_W = SCL_W + RCP_W;

	logic             busy_q;
	logic             done_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVD_W-1:0] quo_q;

	logic [PRD_W-1:0] prod;

	// drop the factor of 32, then multiply by the reciprocal of 25
	assign prod = PRD_W'(dvd_q[DVD_W-1:DIV_PRE]) * PRD_W'(DIV_RCP);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= dreq.start;
			done_q <= busy_q;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (dreq.start) begin
			dvd_q <= dreq.dividend;
		end
		if (busy_q) begin
			quo_q <= DVD_W'(prod[PRD_W-1:RCP_SH]);
		end
	end

	assign drsp.done = done_q;
	assign drsp.quo  = quo_q;

endmodule

`default_nettype wire

// ----- rtl/fmtps_seq.sv -----
// ----------------------------------------------------------------------------
// fmtps_seq - request sequencer
// Holds volume and mute state, drives the divider and steps out the port
// bytes of each request one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module fmtps_seq #(
	parameter int unsigned FREQ_BITS = fmtps_pkg::FREQ_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	fmtps_req_if.sink           req,
	input  logic                take,
	output fmtps_pkg::emit_t    emit,
	output fmtps_pkg::div_req_t dreq,
	input  fmtps_pkg::div_rsp_t drsp
);
	import fmtps_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_FBIT = 3'd2;
	localparam logic [2:0] S_FEND = 3'd3;
	localparam logic [2:0] S_RAMP = 3'd4;
	localparam logic [2:0] S_STEP = 3'd5;
	localparam logic [2:0] S_ONE  = 3'd6;

	localparam logic [DVD_W-1:0] FMASK = DVD_W'((64'd1 << FREQ_BITS) - 64'd1);

	logic [2:0]           state_q;
	logic                 ph_q;
	logic [VOL_W-1:0]     vol_q;
	logic                 mute_q;
	logic [VOL_W-1:0]     tgt_q;
	logic                 up_q;
	logic                 on_q;
	logic [WORD_LEN-1:0]  word_q;
	logic [BIT_CNT_W-1:0] cnt_q;
	logic [BYTE_W-1:0]    one_byte_q;
	logic                 one_wv_q;
	logic                 one_sp_q;

	logic [VOL_W-1:0]     vol_nx;
	logic                 acc;

	assign req.ready = (state_q == S_IDLE);
	assign acc       = req.valid && req.ready;
	assign vol_nx    = up_q ? vol_q + 1'b1 : vol_q - 1'b1;

	// divider launch on a frequency request
	assign dreq.start    = acc && (req.req_type == REQ_FREQ);
	assign dreq.dividend = DVD_W'(req.tune_freq) + IF_OFFSET;

	// result for the current step
	always_comb begin
		emit.valid          = 1'b0;
		emit.port_byte      = PORT_NONE;
		emit.wait_code      = WAIT_NONE;
		emit.write_valid    = 1'b1;
		emit.signal_present = 1'b0;
		emit.last           = 1'b0;
		unique case (state_q)
			S_FBIT: begin
				emit.valid     = 1'b1;
				emit.port_byte = PORT_BIT_BASE | {4'b0, on_q, word_q[0], ph_q, 1'b0};
				emit.wait_code = ph_q ? WAIT_1MS : WAIT_NONE;
			end
			S_FEND: begin
				emit.valid     = 1'b1;
				emit.port_byte = on_q ? PORT_ON : PORT_OFF;
				emit.last      = 1'b1;
			end
			S_RAMP: begin
				emit.valid     = 1'b1;
				emit.port_byte = ph_q ? PORT_OFF : PORT_RAMP_DOWN;
				emit.wait_code = ph_q ? WAIT_NONE : WAIT_2S;
				emit.last      = ph_q;
			end
			S_STEP: begin
				emit.valid     = 1'b1;
				emit.port_byte = ph_q ? PORT_ON : (up_q ? PORT_VOL_UP : PORT_VOL_DOWN);
				emit.wait_code = ph_q ? WAIT_NONE : WAIT_100MS;
				emit.last      = ph_q && (vol_nx == tgt_q);
			end
			S_ONE: begin
				emit.valid          = 1'b1;
				emit.port_byte      = one_byte_q;
				emit.write_valid    = one_wv_q;
				emit.signal_present = one_sp_q;
				emit.last           = 1'b1;
			end
			default: begin
				emit.valid = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q    <= 1'b0;
			vol_q   <= '0;
			mute_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					ph_q <= 1'b0;
					if (acc) begin
						unique case (req.req_type)
							REQ_FREQ: state_q <= S_DIV;
							REQ_VOL: begin
								if (req.volume_level == vol_q) begin
									if (mute_q) begin
										mute_q  <= 1'b0;
										state_q <= S_ONE;
									end
								end else if (req.volume_level == '0) begin
									state_q <= S_RAMP;
								end else begin
									mute_q  <= 1'b0;
									state_q <= S_STEP;
								end
							end
							REQ_MUTE: begin
								mute_q  <= 1'b1;
								state_q <= S_ONE;
							end
							REQ_QUERY: state_q <= S_ONE;
							default:   state_q <= S_IDLE;
						endcase
					end
				end
				S_DIV: begin
					if (drsp.done) state_q <= S_FBIT;
				end
				S_FBIT: begin
					if (take) begin
						ph_q <= !ph_q;
						if (ph_q && cnt_q == BIT_CNT_W'(WORD_LEN-1)) state_q <= S_FEND;
					end
				end
				S_FEND: begin
					if (take) state_q <= S_IDLE;
				end
				S_RAMP: begin
					if (take) begin
						ph_q <= !ph_q;
						if (ph_q) begin
							vol_q   <= '0;
							state_q <= S_IDLE;
						end
					end
				end
				S_STEP: begin
					if (take) begin
						ph_q <= !ph_q;
						if (ph_q) begin
							vol_q <= vol_nx;
							if (vol_nx == tgt_q) state_q <= S_IDLE;
						end
					end
				end
				S_ONE: begin
					if (take) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request payload and tuning word
	always_ff @(posedge clk) begin
		if (acc) begin
			on_q       <= (vol_q != '0) && !mute_q;
			tgt_q      <= req.volume_level;
			up_q       <= req.volume_level > vol_q;
			one_byte_q <= PORT_NONE;
			one_wv_q   <= 1'b0;
			one_sp_q   <= 1'b0;
			unique case (req.req_type)
				REQ_VOL:   begin one_byte_q <= PORT_ON;  one_wv_q <= 1'b1; end
				REQ_MUTE:  begin one_byte_q <= PORT_OFF; one_wv_q <= 1'b1; end
				REQ_QUERY: one_sp_q <= !req.port_read[1];
				default:   one_wv_q <= 1'b1;
			endcase
		end
		if (state_q == S_DIV && drsp.done) begin
			word_q <= WORD_TAIL | WORD_LEN'({drsp.quo & FMASK, 1'b0});
			cnt_q  <= '0;
		end else if (state_q == S_FBIT && take && ph_q) begin
			word_q <= {1'b0, word_q[WORD_LEN-1:1]};
			cnt_q  <= cnt_q + 1'b1;
		end
	end

	// divider only finishes while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> state_q == S_DIV)
		else $error("divider done outside divide wait");

	// stepping never runs with the volume already at target
	a_step_tgt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_STEP |-> vol_q != tgt_q)
		else $error("volume stepping at target");

	// the final result of a run returns the sequencer to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid && take && emit.last |=> state_q == S_IDLE)
		else $error("sequencer busy after last result");

endmodule

`default_nettype wire

// ----- rtl/fm_tuner_port_sequencer.sv -----
// ----------------------------------------------------------------------------
// fm_tuner_port_sequencer - FM tuner card port sequencer
// Turns tuner requests into runs of control port bytes with delay codes.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                         | flow
//  req     | in  | req_type, tune_freq, volume_level, port_read     | valid/ready
//  res     | out | port_byte, wait_code, write_valid, signal_present,| valid/ready
//          |     | last                                             |
//
//  One request at a time; ready is high only while the sequencer idles.
//  Set frequency: accept and latch the dividend, reciprocal multiply, load the
//  word, then 49 results at one per cycle when the output does not stall.
//  Volume: up to 30 results, one per cycle; mute and signal query: 1 result.
//  Reset clears volume step, mute flag and all handshake state.
//  A stalled result holds in the output register; the sequencer waits.
// ----------------------------------------------------------------------------
`default_nettype none

module fm_tuner_port_sequencer #(
	parameter int unsigned FREQ_BITS = fmtps_pkg::FREQ_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	fmtps_req_if.sink req,
	fmtps_res_if.source res
);
	import fmtps_pkg::*;

	emit_t    emit;
	div_req_t dreq;
	div_rsp_t drsp;
	logic     take;

	logic              out_valid_q;
	logic [BYTE_W-1:0] port_byte_q;
	logic [WAIT_W-1:0] wait_code_q;
	logic              write_valid_q;
	logic              signal_present_q;
	logic              last_q;

	fmtps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.dreq   (dreq),
		.drsp   (drsp)
	);

	fmtps_seq #(
		.FREQ_BITS (FREQ_BITS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.take   (take),
		.emit   (emit),
		.dreq   (dreq),
		.drsp   (drsp)
	);

	// output register takes a new result when empty or being drained
	assign take = emit.valid && (!out_valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			port_byte_q      <= emit.port_byte;
			wait_code_q      <= emit.wait_code;
			write_valid_q    <= emit.write_valid;
			signal_present_q <= emit.signal_present;
			last_q           <= emit.last;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.port_byte      = port_byte_q;
	assign res.wait_code      = wait_code_q;
	assign res.write_valid    = write_valid_q;
	assign res.signal_present = signal_present_q;
	assign res.last           = last_q;

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - testbench of the FM tuner port sequencer
// Drives tuner requests through the request channel with random gaps. An
// in-bench model of volume step and mute state works out the port byte runs.
// Every result is compared field by field, in order, against that model.
// ----------------------------------------------------------------------------

module tb_top;
	import fmtps_pkg::*;

	localparam int unsigned FREQ_BITS    = FREQ_BITS_DEF;
	localparam int          HOLD_CYCLES  = 400;   // long receiver hold-off
	localparam int          STALL_LIMIT  = 2000;  // cycles with no handshake
	localparam int          DRAIN_CYCLES = 100;   // quiet time after last result
	localparam int          MAX_REPORTS  = 30;
	localparam int          RANDOM_ITEMS = 260;

	// bit masks inside a tuning word byte
	localparam logic [BYTE_W-1:0] CARD_ON_BIT = 8'h08;
	localparam logic [BYTE_W-1:0] DATA_BIT    = 8'h04;
	localparam logic [BYTE_W-1:0] CLOCK_BIT   = 8'h02;

	typedef struct {
		logic [REQ_W-1:0]  req_type;
		logic [FREQ_W-1:0] tune_freq;
		logic [VOL_W-1:0]  volume_level;
		logic [BYTE_W-1:0] port_read;
	} tuner_req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] port_byte;
		logic [WAIT_W-1:0] wait_code;
		logic              write_valid;
		logic              signal_present;
		logic              last;
	} port_res_t;

	logic clk = 1'b0;
	logic arst_n;

	fmtps_req_if req_ch ();
	fmtps_res_if res_ch ();

	fm_tuner_port_sequencer #(
		.FREQ_BITS(FREQ_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch)
	);

	// model state and expected port bytes
	logic [VOL_W-1:0] vol_step_m;
	logic             muted_m;
	port_res_t        exp_port_q[$];

	int  errors = 0;
	int  result_idx = 0;
	int  productive_items = 0;
	bit  steady = 1'b0;
	bit  hold_pending = 1'b0;

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// mostly short gaps, a few long ones; none while steady
	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 48);
	endfunction

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	task automatic check_field(input string name, input logic [BYTE_W-1:0] got,
			input logic [BYTE_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s got %0h want %0h",
				result_idx, name, got, want));
	endtask

	function automatic void push_port(input logic [BYTE_W-1:0] pbyte,
			input logic [WAIT_W-1:0] wcode);
		port_res_t e;
		e.port_byte      = pbyte;
		e.wait_code      = wcode;
		e.write_valid    = 1'b1;
		e.signal_present = 1'b0;
		e.last           = 1'b0;
		exp_port_q.push_back(e);
	endfunction

	// Works out the port run of one accepted request and updates the model.
	// Returns the number of results the request causes.
	function automatic int predict_port_run(input tuner_req_t r);
		int unsigned      quo;
		logic [WORD_LEN-1:0] word;
		logic [BYTE_W-1:0] base;
		logic [BYTE_W-1:0] b;
		logic             card_on;
		port_res_t        e;
		int               n0;
		n0 = exp_port_q.size();
		case (r.req_type)
			REQ_FREQ: begin
				quo = (32'(r.tune_freq) + 32'(IF_OFFSET)) / FREQ_DIV;
				word = WORD_TAIL | WORD_LEN'((quo & ((32'd1 << FREQ_BITS) - 1)) << 1);
				card_on = (vol_step_m != '0) && !muted_m;
				base = PORT_BIT_BASE | (card_on ? CARD_ON_BIT : '0);
				// data write then clock write per word bit, LSB first
				for (int i = 0; i < WORD_LEN; i++) begin
					b = base | (word[i] ? DATA_BIT : '0);
					push_port(b, WAIT_NONE);
					push_port(b | CLOCK_BIT, WAIT_1MS);
				end
				push_port(card_on ? PORT_ON : PORT_OFF, WAIT_NONE);
			end
			REQ_VOL: begin
				if (r.volume_level == vol_step_m) begin
					// same level: only unmutes, else nothing at all
					if (muted_m) begin
						muted_m = 1'b0;
						push_port(PORT_ON, WAIT_NONE);
					end
				end else if (r.volume_level == '0) begin
					push_port(PORT_RAMP_DOWN, WAIT_2S);
					push_port(PORT_OFF, WAIT_NONE);
					vol_step_m = '0;
				end else begin
					muted_m = 1'b0;
					if (r.volume_level > vol_step_m) begin
						repeat (r.volume_level - vol_step_m) begin
							push_port(PORT_VOL_UP, WAIT_100MS);
							push_port(PORT_ON, WAIT_NONE);
						end
					end else begin
						repeat (vol_step_m - r.volume_level) begin
							push_port(PORT_VOL_DOWN, WAIT_100MS);
							push_port(PORT_ON, WAIT_NONE);
						end
					end
					vol_step_m = r.volume_level;
				end
			end
			REQ_MUTE: begin
				muted_m = 1'b1;
				push_port(PORT_OFF, WAIT_NONE);
			end
			default: begin
				// signal query: port bit 1 clear means signal present
				e.port_byte      = PORT_NONE;
				e.wait_code      = WAIT_NONE;
				e.write_valid    = 1'b0;
				e.signal_present = !r.port_read[1];
				e.last           = 1'b0;
				exp_port_q.push_back(e);
			end
		endcase
		if (exp_port_q.size() > n0)
			exp_port_q[exp_port_q.size() - 1].last = 1'b1;
		return exp_port_q.size() - n0;
	endfunction

	function automatic tuner_req_t make_req(input logic [REQ_W-1:0] kind,
			input logic [FREQ_W-1:0] freq, input logic [VOL_W-1:0] vol,
			input logic [BYTE_W-1:0] pread);
		tuner_req_t r;
		r.req_type     = kind;
		r.tune_freq    = freq;
		r.volume_level = vol;
		r.port_read    = pread;
		return r;
	endfunction

	function automatic tuner_req_t rand_req();
		tuner_req_t r;
		int         pick;
		pick = $urandom_range(0, 99);
		if (pick < 25)
			r.req_type = REQ_FREQ;
		else if (pick < 65)
			r.req_type = REQ_VOL;
		else if (pick < 78)
			r.req_type = REQ_MUTE;
		else
			r.req_type = REQ_QUERY;
		if ($urandom_range(0, 9) < 8)
			r.tune_freq = FREQ_W'($urandom_range(0, (1 << FREQ_W) - 1));
		else
			r.tune_freq = $urandom_range(0, 1) ? '1 : '0;
		// hit the same-level cases often
		if ($urandom_range(0, 3) == 0)
			r.volume_level = vol_step_m;
		else
			r.volume_level = VOL_W'($urandom_range(0, (1 << VOL_W) - 1));
		r.port_read = BYTE_W'($urandom_range(0, 255));
		return r;
	endfunction

	// send one request; valid stays high after acceptance until the next call
	task automatic send_req(input tuner_req_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.req_type     <= r.req_type;
		req_ch.tune_freq    <= r.tune_freq;
		req_ch.volume_level <= r.volume_level;
		req_ch.port_read    <= r.port_read;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		if (predict_port_run(r) > 0)
			productive_items++;
	endtask

	// result receiver with random stalls and one long hold-off on request
	initial begin : result_sink
		int stall;
		res_ch.ready <= 1'b0;
		forever begin
			if (hold_pending) begin
				hold_pending = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				stall = pick_gap();
				if (stall > 0) begin
					res_ch.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end else begin
					res_ch.ready <= 1'b1;
					@(posedge clk);
				end
			end
		end
	end

	// result checker
	always @(posedge clk) begin : check_results
		port_res_t want;
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (exp_port_q.size() == 0) begin
				report_mismatch($sformatf("result %0d byte %0h with nothing pending",
					result_idx, res_ch.port_byte));
			end else begin
				want = exp_port_q.pop_front();
				check_field("port_byte", res_ch.port_byte, want.port_byte);
				check_field("wait_code", BYTE_W'(res_ch.wait_code), BYTE_W'(want.wait_code));
				check_field("write_valid", BYTE_W'(res_ch.write_valid),
					BYTE_W'(want.write_valid));
				check_field("signal_present", BYTE_W'(res_ch.signal_present),
					BYTE_W'(want.signal_present));
				check_field("last", BYTE_W'(res_ch.last), BYTE_W'(want.last));
			end
			result_idx++;
		end
	end

	// watchdog: ends the run when no handshake happens for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
					(res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// signal query with port bit 1 set and clear
	task automatic test_signal_query();
		send_req(make_req(REQ_QUERY, '1, '1, 8'h00));
		send_req(make_req(REQ_QUERY, '0, '0, 8'hFF));
		send_req(make_req(REQ_QUERY, '1, '0, 8'h02));
		send_req(make_req(REQ_QUERY, '0, '1, 8'hFD));
	endtask

	// tuning word with the card off, lowest and highest frequency
	task automatic test_freq_card_off();
		send_req(make_req(REQ_FREQ, '0, '1, 8'hFF));
		send_req(make_req(REQ_FREQ, '1, '0, 8'h00));
	endtask

	// volume stepping, same level, mute and unmute, ramp to zero
	task automatic test_volume_and_mute();
		send_req(make_req(REQ_VOL, '0, 4'd9, '0));         // up from zero
		send_req(make_req(REQ_VOL, '1, 4'd9, '0));         // same level, no output
		send_req(make_req(REQ_MUTE, '0, '0, '0));
		send_req(make_req(REQ_VOL, '0, 4'd9, '1));         // same level unmutes
		send_req(make_req(REQ_VOL, '0, 4'd3, '0));         // down
		send_req(make_req(REQ_FREQ, 21'd1000000, '0, '0)); // card on
		send_req(make_req(REQ_MUTE, '0, '0, '0));
		send_req(make_req(REQ_FREQ, 21'd55555, '0, '0));   // muted, card off
		send_req(make_req(REQ_VOL, '0, 4'd15, '0));        // up clears mute
		send_req(make_req(REQ_VOL, '1, 4'd0, '1));         // ramp down
		send_req(make_req(REQ_VOL, '0, 4'd15, '0));        // longest run
		send_req(make_req(REQ_VOL, '0, 4'd0, '0));
		send_req(make_req(REQ_MUTE, '1, '1, '1));
		send_req(make_req(REQ_VOL, '0, 4'd0, '0));         // unmute at zero
	endtask

	// back-to-back stream with no idling on either side
	task automatic test_steady_stream();
		steady = 1'b1;
		repeat (20) send_req(rand_req());
		steady = 1'b0;
	endtask

	// receiver holds off long while requests keep coming
	task automatic test_output_hold_off();
		steady = 1'b1;
		hold_pending = 1'b1;
		send_req(make_req(REQ_FREQ, 21'd1500000, '0, '0));
		repeat (6) send_req(rand_req());
		steady = 1'b0;
	endtask

	task automatic test_random_requests();
		int target;
		target = productive_items + RANDOM_ITEMS;
		while (productive_items < target)
			send_req(rand_req());
	endtask

	// main sequence
	initial begin
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.req_type     = REQ_FREQ;
		req_ch.tune_freq    = '0;
		req_ch.volume_level = '0;
		req_ch.port_read    = '0;
		vol_step_m          = '0;
		muted_m             = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_signal_query();
		test_freq_card_off();
		test_volume_and_mute();
		test_steady_stream();
		test_output_hold_off();
		test_random_requests();
		req_ch.valid <= 1'b0;

		// drain outstanding results, then watch for strays
		while (exp_port_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
